FILE: rtl/bst_pkg.sv
package bst_pkg;

    // Table geometry.
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;

    // Widths that follow from the geometry.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed widths of the request and response fields.
    localparam int REQ_TYPE_W = 2;
    localparam int FIELD_W    = 32;
    localparam int FIELD_IDX_W = 5;
    localparam int FIELD_CNT_W = 6;

    // Width used when comparing request indices against the fill level.
    localparam int CMP_W = (CNT_W > FIELD_IDX_W) ? CNT_W : FIELD_IDX_W;

    typedef enum logic [REQ_TYPE_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_RANGE  = 2'd2
    } req_type_t;

endpackage

FILE: rtl/bst_ifs.sv
interface bst_req_if import bst_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic [REQ_TYPE_W-1:0]        req_type;
    logic signed [FIELD_W-1:0]    value;
    logic [FIELD_IDX_W-1:0]       from_index;
    logic [FIELD_IDX_W-1:0]       to_index;

    modport source (output valid, output req_type, output value, output from_index,
                    output to_index, input ready);
    modport sink   (input valid, input req_type, input value, input from_index,
                    input to_index, output ready);
endinterface

interface bst_rsp_if import bst_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic signed [FIELD_W-1:0]    data;
    logic                         last;
    logic [FIELD_CNT_W-1:0]       count;

    modport source (output valid, output ok, output data, output last, output count,
                    input ready);
    modport sink   (input valid, input ok, input data, input last, input count,
                    output ready);
endinterface

interface bst_cfg_if ();
    logic valid;
    logic ready;
    logic allow_duplicates;

    modport source (output valid, output allow_duplicates, input ready);
    modport sink   (input valid, input allow_duplicates, output ready);
endinterface

FILE: rtl/bounded_set_table.sv
// Bounded set table: an unordered table of up to CAPACITY values held in one
// synchronous single-read, single-write memory. An insert appends at the fill
// level; with duplicates allowed (the reset setting) it needs no search, and its
// response passes through the S_RESP state into the response register. With
// duplicates barred, for an insert into a table that is not full, and for every
// remove, the stored entries are scanned one per cycle; a remove that finds its
// value then moves the last entry into the freed slot. In a range read each
// entry is read from memory only once the one before it has gone on into
// the response register. Each request produces exactly one response with last
// set, except a non-empty range read, which produces one response per entry and
// sets last on the final one. The count field always reports the fill level after
// the request. Requests are taken one at a time; a new request is accepted while
// the previous response still waits in the output register. Configuration is
// taken at any time but should only be changed while the table is idle.
module bounded_set_table
    import bst_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bst_req_if.sink      req,
    bst_rsp_if.source    rsp,
    bst_cfg_if.sink      cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MOVE_RD,
        S_MOVE_WR,
        S_RESP,
        S_R_ISSUE,
        S_R_EMIT
    } state_t;

    // Entry storage: one read port with registered data, one write port.
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic [VALUE_WIDTH-1:0] rdata_reg;
    logic                   mem_rd_en;
    logic [IDX_W-1:0]       mem_rd_addr;
    logic                   mem_wr_en;
    logic [IDX_W-1:0]       mem_wr_addr;
    logic [VALUE_WIDTH-1:0] mem_wr_data;

    state_t                 state_reg,     state_next;
    logic [CNT_W-1:0]       count_reg,     count_next;
    logic                   allow_dup_reg, allow_dup_next;
    logic [VALUE_WIDTH-1:0] val_reg,       val_next;
    logic                   op_remove_reg, op_remove_next;
    logic [CNT_W-1:0]       scan_idx_reg,  scan_idx_next;
    logic                   cmp_vld_reg,   cmp_vld_next;
    logic [IDX_W-1:0]       cmp_idx_reg,   cmp_idx_next;
    logic [IDX_W-1:0]       idx_reg,       idx_next;
    logic [IDX_W-1:0]       hi_reg,        hi_next;
    logic                   resp_ok_reg,   resp_ok_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   out_ok_reg,    out_ok_next;
    logic [FIELD_W-1:0]     out_data_reg,  out_data_next;
    logic                   out_last_reg,  out_last_next;
    logic [CNT_W-1:0]       out_count_reg, out_count_next;

    logic                   out_free;
    logic [CMP_W-1:0]       top_idx;
    logic [CMP_W-1:0]       hi_idx;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid = out_valid_reg;
    assign rsp.ok    = out_ok_reg;
    assign rsp.data  = out_data_reg;
    assign rsp.last  = out_last_reg;
    assign rsp.count = FIELD_CNT_W'(out_count_reg);

    // The response register can take a new result when it is empty or draining.
    assign out_free = !out_valid_reg || rsp.ready;

    // Clamped upper bound of a range read; only used when the table is not empty.
    assign top_idx = CMP_W'(count_reg - CNT_W'(1));
    assign hi_idx  = (CMP_W'(req.to_index) > top_idx) ? top_idx : CMP_W'(req.to_index);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        allow_dup_next = allow_dup_reg;
        val_next       = val_reg;
        op_remove_next = op_remove_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_vld_next   = cmp_vld_reg;
        cmp_idx_next   = cmp_idx_reg;
        idx_next       = idx_reg;
        hi_next        = hi_reg;
        resp_ok_next   = resp_ok_reg;
        out_valid_next = out_valid_reg;
        out_ok_next    = out_ok_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_count_next = out_count_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = cmp_idx_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = IDX_W'(count_reg);
        mem_wr_data    = val_reg;

        if (cfg.valid)
        begin
            allow_dup_next = cfg.allow_duplicates;
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    val_next       = VALUE_WIDTH'(req.value);
                    op_remove_next = (req.req_type == REQ_REMOVE);
                    scan_idx_next  = '0;
                    cmp_vld_next   = 1'b0;
                    resp_ok_next   = 1'b0;
                    state_next     = S_RESP;
                    case (req.req_type)
                        REQ_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                resp_ok_next = 1'b0;
                            end
                            else if (allow_dup_reg)
                            begin
                                // No search needed: append straight away.
                                mem_wr_en    = 1'b1;
                                mem_wr_addr  = IDX_W'(count_reg);
                                mem_wr_data  = VALUE_WIDTH'(req.value);
                                count_next   = count_reg + CNT_W'(1);
                                resp_ok_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            state_next = S_SCAN;
                        end
                        REQ_RANGE:
                        begin
                            if (count_reg != '0 && CMP_W'(req.from_index) <= hi_idx)
                            begin
                                idx_next   = IDX_W'(req.from_index);
                                hi_next    = IDX_W'(hi_idx);
                                state_next = S_R_ISSUE;
                            end
                        end
                        default:
                        begin
                            resp_ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Reads are issued one entry per cycle and each is compared in the following cycle.
                if (cmp_vld_reg && rdata_reg == val_reg)
                begin
                    cmp_vld_next = 1'b0;
                    if (op_remove_reg)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        resp_ok_next = 1'b0;
                        state_next   = S_RESP;
                    end
                end
                else if (scan_idx_reg < count_reg)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = IDX_W'(scan_idx_reg);
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = IDX_W'(scan_idx_reg);
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    state_next   = S_RESP;
                    if (op_remove_reg)
                    begin
                        resp_ok_next = 1'b0;
                    end
                    else
                    begin
                        mem_wr_en    = 1'b1;
                        mem_wr_addr  = IDX_W'(count_reg);
                        mem_wr_data  = val_reg;
                        count_next   = count_reg + CNT_W'(1);
                        resp_ok_next = 1'b1;
                    end
                end
            end

            S_MOVE_RD:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = IDX_W'(count_reg - CNT_W'(1));
                state_next  = S_MOVE_WR;
            end

            S_MOVE_WR:
            begin
                // The last entry fills the slot of the removed one.
                mem_wr_en    = 1'b1;
                mem_wr_addr  = cmp_idx_reg;
                mem_wr_data  = rdata_reg;
                count_next   = count_reg - CNT_W'(1);
                resp_ok_next = 1'b1;
                state_next   = S_RESP;
            end

            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = resp_ok_reg;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    out_count_next = count_reg;
                    state_next     = S_IDLE;
                end
            end

            S_R_ISSUE:
            begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = idx_reg;
                state_next  = S_R_EMIT;
            end

            S_R_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    out_data_next  = FIELD_W'(signed'(rdata_reg));
                    out_last_next  = (idx_reg == hi_reg);
                    out_count_next = count_reg;
                    if (idx_reg == hi_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_R_ISSUE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            allow_dup_reg <= 1'b1;
            op_remove_reg <= 1'b0;
            scan_idx_reg  <= '0;
            cmp_vld_reg   <= 1'b0;
            resp_ok_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            val_reg       <= '0;
            cmp_idx_reg   <= '0;
            idx_reg       <= '0;
            hi_reg        <= '0;
            out_ok_reg    <= 1'b0;
            out_data_reg  <= '0;
            out_last_reg  <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            allow_dup_reg <= allow_dup_next;
            op_remove_reg <= op_remove_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            resp_ok_reg   <= resp_ok_next;
            out_valid_reg <= out_valid_next;
            val_reg       <= val_next;
            cmp_idx_reg   <= cmp_idx_next;
            idx_reg       <= idx_next;
            hi_reg        <= hi_next;
            out_ok_reg    <= out_ok_next;
            out_data_reg  <= out_data_next;
            out_last_reg  <= out_last_next;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
        begin
            mem[mem_wr_addr] <= mem_wr_data;
        end
        if (mem_rd_en)
        begin
            rdata_reg <= mem[mem_rd_addr];
        end
    end

`ifndef SYNTHESIS
    // The fill level never exceeds the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill level above capacity");

    // The fill level moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |->
            (count_reg == $past(count_reg) + CNT_W'(1)) ||
            (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("fill level jumped");

    // A transfer on the request side always starts work away from idle.
    a_req_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> state_reg != S_IDLE)
        else $error("accepted request left no trace");

    // Writes land only inside the occupied region or at the append slot.
    a_write_region: assert property (@(posedge clk) disable iff (!rst_n)
        mem_wr_en |-> (CNT_W'(mem_wr_addr) <= count_reg) &&
                      (count_reg < CNT_W'(CAPACITY) || state_reg == S_MOVE_WR))
        else $error("write outside the table");
`endif

endmodule

FILE: tb/sv/bst_response_checker.sv
`timescale 1ns / 1ps

module bst_response_checker
    import bst_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bst_req_if   req,
    bst_rsp_if   rsp,
    bst_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic                      ok;
        logic signed [FIELD_W-1:0] data;
        logic                      last;
        logic [FIELD_CNT_W-1:0]    count;
    } rsp_beat_t;

    // Mirror of the table contents and of the duplicate setting.
    logic [VALUE_WIDTH-1:0] shadow_entries [CAPACITY];
    int unsigned            shadow_fill;
    logic                   shadow_dup_ok;
    rsp_beat_t              awaited_beats [$];
    int                     fault_tally;

    function automatic rsp_beat_t make_beat(logic ok, logic signed [FIELD_W-1:0] data,
                                            logic last);
        rsp_beat_t beat;
        beat.ok    = ok;
        beat.data  = data;
        beat.last  = last;
        beat.count = FIELD_CNT_W'(shadow_fill);
        return beat;
    endfunction

    // Applies one accepted request to the mirror and queues the responses it must produce.
    function automatic void mirror_request(logic [REQ_TYPE_W-1:0] kind_bits,
                                           logic [FIELD_W-1:0] value,
                                           logic [FIELD_IDX_W-1:0] lo,
                                           logic [FIELD_IDX_W-1:0] hi_req);
        logic [VALUE_WIDTH-1:0] key;
        logic                   hit;
        int unsigned            hi;
        key = value[VALUE_WIDTH-1:0];
        hit = 1'b0;
        case (kind_bits)
            REQ_INSERT:
            begin
                hit = (shadow_fill < CAPACITY);
                if (hit && !shadow_dup_ok)
                    for (int i = 0; i < shadow_fill; i++)
                        if (shadow_entries[i] == key)
                            hit = 1'b0;
                if (hit)
                begin
                    shadow_entries[shadow_fill] = key;
                    shadow_fill++;
                end
                awaited_beats.push_back(make_beat(hit, '0, 1'b1));
            end
            REQ_REMOVE:
            begin
                for (int i = 0; i < shadow_fill; i++)
                    if (!hit && shadow_entries[i] == key)
                    begin
                        shadow_fill--;
                        shadow_entries[i] = shadow_entries[shadow_fill];
                        hit = 1'b1;
                    end
                awaited_beats.push_back(make_beat(hit, '0, 1'b1));
            end
            REQ_RANGE:
            begin
                if (shadow_fill == 0)
                    awaited_beats.push_back(make_beat(1'b0, '0, 1'b1));
                else
                begin
                    hi = (hi_req > shadow_fill - 1) ? shadow_fill - 1 : hi_req;
                    if (lo > hi)
                        awaited_beats.push_back(make_beat(1'b0, '0, 1'b1));
                    else
                        for (int unsigned i = lo; i <= hi; i++)
                            awaited_beats.push_back(make_beat(1'b1,
                                FIELD_W'($signed(shadow_entries[i])), i == hi));
                end
            end
            default:
                awaited_beats.push_back(make_beat(1'b0, '0, 1'b1));
        endcase
    endfunction

    function automatic void check_beat();
        rsp_beat_t want;
        if (awaited_beats.size() == 0)
        begin
            $error("response with none awaited: ok %0d data %0d last %0d count %0d",
                   rsp.ok, rsp.data, rsp.last, rsp.count);
            fault_tally++;
        end
        else
        begin
            want = awaited_beats.pop_front();
            if (rsp.ok !== want.ok)
            begin
                $error("ok: expected %0d, got %0d", want.ok, rsp.ok);
                fault_tally++;
            end
            if (rsp.data !== want.data)
            begin
                $error("data: expected %0d, got %0d", want.data, rsp.data);
                fault_tally++;
            end
            if (rsp.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, rsp.last);
                fault_tally++;
            end
            if (rsp.count !== want.count)
            begin
                $error("count: expected %0d, got %0d", want.count, rsp.count);
                fault_tally++;
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill   = 0;
            shadow_dup_ok = 1'b1;
            fault_tally   = 0;
            awaited_beats.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                shadow_dup_ok = cfg.allow_duplicates;
            if (rsp.valid && rsp.ready)
                check_beat();
            if (req.valid && req.ready)
                mirror_request(req.req_type, req.value, req.from_index, req.to_index);
            mismatches  <= fault_tally;
            outstanding <= awaited_beats.size();
        end
    end

endmodule

FILE: tb/sv/bounded_set_table_tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the bounded set table. All prediction and comparison
// lives in the response checker, which watches the three channels beside the block
// and reports how many mismatches it has seen and how many responses it still awaits.
module bounded_set_table_tb;
    import bst_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    // Far above the slowest legal run: every request a full 32-entry range read,
    // every response held back by the longest stall, every request after the
    // longest sender gap.
    localparam int LIMIT_CYCLES = 1_500_000;
    localparam int PHASES       = 11;
    localparam int PHASE_ITEMS  = 42;
    localparam int POOL_SIZE    = 16;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;

    // Idling control, shared with the response-side process. When quiet is set,
    // neither side idles any more.
    bit   quiet           = 1'b0;
    int   sender_idle_pct = 0;
    int   stall_pct       = 0;

    // A small pool of values, drawn from often, so that removes find their value
    // and inserts meet duplicates when those are barred.
    logic [FIELD_W-1:0] value_pool [POOL_SIZE];

    bst_req_if req ();
    bst_rsp_if rsp ();
    bst_cfg_if cfg ();

    bounded_set_table dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    bst_response_checker table_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .cfg         (cfg),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The run is cut short here if the block ever stops answering.
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("== FAIL ==");
        $finish;
    end

    // Response side: ready is held high for runs of random length, broken now and
    // then by a stall, so that stalls land on single-entry answers as well as in
    // the middle of long range reads.
    initial
    begin
        forever
        begin
            rsp.ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                rsp.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Offers one request and returns at the clock edge at which it is transferred.
    // A gap, when one is drawn, lowers valid before the request is raised again.
    task automatic send_request(req_type_t kind, logic [FIELD_W-1:0] value,
                                logic [FIELD_IDX_W-1:0] lo, logic [FIELD_IDX_W-1:0] hi);
        if (!quiet && $urandom_range(0, 99) < sender_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.value      <= value;
        req.from_index <= lo;
        req.to_index   <= hi;
        do @(posedge clk); while (!req.ready);
    endtask

    // Holds the request side idle until every awaited response has arrived. The
    // checker's count is registered, so the first look is taken after the next edge.
    task automatic drain_responses();
        req.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // The setting is only changed once the table has gone quiet.
    task automatic write_config(logic dup_ok);
        drain_responses();
        cfg.valid            <= 1'b1;
        cfg.allow_duplicates <= dup_ok;
        do @(posedge clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return value_pool[$urandom_range(0, POOL_SIZE - 1)];
            6:                return FIELD_W'($urandom_range(0, 7));
            default:          return $urandom;
        endcase
    endfunction

    initial
    begin
        req_type_t              kind;
        logic [FIELD_IDX_W-1:0] lo;
        logic [FIELD_IDX_W-1:0] hi;
        int                     roll;
        int                     ins_pct;
        int                     rem_pct;

        // Every input of the block is known from the very start.
        rst_n                <= 1'b0;
        req.valid            <= 1'b0;
        req.req_type         <= REQ_INSERT;
        req.value            <= '0;
        req.from_index       <= '0;
        req.to_index         <= '0;
        cfg.valid            <= 1'b0;
        cfg.allow_duplicates <= 1'b1;

        value_pool[0] = 32'h7FFF_FFFF;
        value_pool[1] = 32'h8000_0000;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        value_pool[4] = 32'h0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            value_pool[i] = $urandom;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with duplicates allowed as after reset. A range read and a
        // remove on the empty table both answer with ok clear.
        send_request(REQ_RANGE, $urandom, 5'd0, 5'd31);
        send_request(REQ_REMOVE, 32'h1234_5678, 5'd0, 5'd0);
        // The extremes of the value field, then the largest value a second time.
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 5'd31, 5'd0);
        send_request(REQ_INSERT, 32'h8000_0000, 5'd0, 5'd31);
        send_request(REQ_INSERT, 32'h0000_0000, 5'd0, 5'd0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 5'd31, 5'd31);
        send_request(REQ_INSERT, 32'h7FFF_FFFF, 5'd0, 5'd0);
        // The upper bound is clamped to the fill level minus one.
        send_request(REQ_RANGE, $urandom, 5'd0, 5'd31);
        // A start above the end, a single entry, and a start beyond the fill level.
        send_request(REQ_RANGE, $urandom, 5'd3, 5'd1);
        send_request(REQ_RANGE, $urandom, 5'd4, 5'd4);
        send_request(REQ_RANGE, $urandom, 5'd31, 5'd31);
        // Removing from the middle moves the last entry into the freed slot; then
        // the entry that is now last goes, and an absent value changes nothing.
        send_request(REQ_REMOVE, 32'h0000_0000, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 32'hFFFF_FFFF, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 32'h0BAD_CAFE, 5'd0, 5'd0);
        send_request(REQ_RANGE, $urandom, 5'd0, 5'd31);

        // With duplicates barred, a stored value is turned away and a new one is kept.
        write_config(1'b0);
        send_request(REQ_INSERT, 32'h8000_0000, 5'd0, 5'd0);
        send_request(REQ_INSERT, 32'h0000_0005, 5'd0, 5'd0);
        send_request(REQ_REMOVE, 32'h7FFF_FFFF, 5'd0, 5'd0);
        send_request(REQ_RANGE, $urandom, 5'd1, 5'd2);

        // Random part, in phases. Each phase begins from an idle table with its setting
        // written anew and its own mix of requests and idling. The first phase opens
        // with a burst of inserts that fills the table and runs past its capacity;
        // the remove-heavy phases empty it again.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase == PHASES - 1);
            case ($urandom_range(0, 2))
                0:       sender_idle_pct = 0;
                1:       sender_idle_pct = 15;
                default: sender_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 30;
                default: stall_pct = 80;
            endcase
            case (phase % 3)
                0:
                begin
                    ins_pct = 70;
                    rem_pct = 10;
                end
                1:
                begin
                    ins_pct = 40;
                    rem_pct = 35;
                end
                default:
                begin
                    ins_pct = 15;
                    rem_pct = 65;
                end
            endcase

            if (phase < 6)
                write_config(phase % 2 == 0);
            else
                write_config(1'($urandom_range(0, 1)));

            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                roll = $urandom_range(0, 99);
                if ((phase == 0 && k < 34) || roll < ins_pct)
                    kind = REQ_INSERT;
                else if (roll < ins_pct + rem_pct)
                    kind = REQ_REMOVE;
                else
                    kind = REQ_RANGE;

                // Range reads lean towards the ends of the index field now and then.
                roll = $urandom_range(0, 3);
                lo   = (roll == 0) ? 5'd0 : FIELD_IDX_W'($urandom_range(0, 31));
                hi   = (roll == 1) ? 5'd31 : FIELD_IDX_W'($urandom_range(0, 31));
                send_request(kind, pick_value(), lo, hi);
            end
        end

        // The last phase ran without idling; wait for the tail, then a little longer
        // so that any stray response is still seen by the checker.
        drain_responses();
        repeat (2 * CAPACITY + 8) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
